[rtl/mer_pkg.sv]
// Shared constants, command codes and control/status types of the ellipse rasterizer.
package mer_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int AXIS_BITS_DEF  = 11;

  // Input item kinds.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Operand pairs of the shared multiplier.
  localparam logic [1:0] MS_TT   = 2'd0;
  localparam logic [1:0] MS_A2T  = 2'd1;
  localparam logic [1:0] MS_B2T  = 2'd2;
  localparam logic [1:0] MS_A2B2 = 2'd3;

  // Loads of the operand register t.
  localparam logic [3:0] T_HOLD = 4'd0;
  localparam logic [3:0] T_AXIS = 4'd1;
  localparam logic [3:0] T_Y    = 4'd2;
  localparam logic [3:0] T_X    = 4'd3;
  localparam logic [3:0] T_PX   = 4'd4;
  localparam logic [3:0] T_YM1  = 4'd5;
  localparam logic [3:0] T_P    = 4'd6;
  localparam logic [3:0] T_2X3  = 4'd7;
  localparam logic [3:0] T_2Y2  = 4'd8;
  localparam logic [3:0] T_2Y   = 4'd9;
  localparam logic [3:0] T_2X2  = 4'd10;

  // Updates of the decision register.
  localparam logic [2:0] DO_NONE = 3'd0;
  localparam logic [2:0] DO_INIT = 3'd1;
  localparam logic [2:0] DO_LOAD = 3'd2;
  localparam logic [2:0] DO_ADD  = 3'd3;
  localparam logic [2:0] DO_SUB  = 3'd4;
  localparam logic [2:0] DO_SUB3 = 3'd5;

  typedef struct packed {
    logic       start;
    logic       a2_load;
    logic       b2_load;
    logic       save_load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic [3:0] t_sel;
    logic [2:0] dec_op;
    logic       x_inc;
    logic       y_dec;
    logic [1:0] beat;
  } mer_cmd_t;

  typedef struct packed {
    logic dec_neg;
    logic dec_pos;
    logic cmp_gt;
    logic y_zero;
  } mer_sts_t;

endpackage

[rtl/mer_req_if.sv]
// Input channel carrying start and step items.
interface mer_req_if import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [AXIS_BITS-1:0]  axis_a;
  logic [AXIS_BITS-1:0]  axis_b;

  modport source (output valid, mode, center_x, center_y, axis_a, axis_b, input ready);
  modport sink (input valid, mode, center_x, center_y, axis_a, axis_b, output ready);
endinterface

[rtl/mer_pix_if.sv]
// Output channel carrying one plotted pixel per beat.
interface mer_pix_if import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS+1:0]   pixel_x;
  logic signed [COORD_BITS+1:0]   pixel_y;
  logic                           last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface

[rtl/mer_dp.sv]
// Datapath: point, axis squares, decision, one shared multiplier and pixel generation.
module mer_dp import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF
) (
  input  logic                         clk,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [AXIS_BITS-1:0]         axis_a,
  input  logic [AXIS_BITS-1:0]         axis_b,
  input  mer_cmd_t                     cmd,
  output mer_sts_t                     sts,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y
);

  localparam int X_W   = AXIS_BITS + 1;
  localparam int Y_W   = AXIS_BITS + 2;
  localparam int SQ_W  = 2 * AXIS_BITS;
  localparam int MW    = 2 * AXIS_BITS + 2;
  localparam int DEC_W = 4 * AXIS_BITS - 4;
  localparam int PW    = COORD_BITS + 2;

  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [X_W-1:0]        x;
  logic [Y_W-1:0]        y;
  logic [SQ_W-1:0]       a2;
  logic [SQ_W-1:0]       b2;
  logic [MW-1:0]         t;
  logic [MW-1:0]         t_next;
  logic [DEC_W-1:0]      prod;
  logic [DEC_W-1:0]      saved;
  logic [DEC_W-1:0]      dec;
  logic [DEC_W-1:0]      dec_next;
  logic [MW-1:0]         mul_a;
  logic [MW-1:0]         mul_b;
  logic [2*MW-1:0]       full_prod;
  logic [PW-1:0]         cxo;
  logic [PW-1:0]         cyo;
  logic [PW-1:0]         xo;
  logic [PW-1:0]         yo;

  // Operand register loads.
  always_comb begin
    unique case (cmd.t_sel)
      T_AXIS:  t_next = MW'(axis_a);
      T_Y:     t_next = MW'(y);
      T_X:     t_next = MW'(x);
      T_PX:    t_next = prod[MW-1:0] + MW'(x);
      T_YM1:   t_next = (y == '0) ? MW'(1) : MW'(y) - MW'(1);
      T_P:     t_next = prod[MW-1:0];
      T_2X3:   t_next = (MW'(x) << 1) + MW'(3);
      T_2Y2:   t_next = (MW'(y) << 1) - MW'(2);
      T_2Y:    t_next = MW'(y) << 1;
      T_2X2:   t_next = (MW'(x) << 1) + MW'(2);
      default: t_next = t;
    endcase
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MS_TT: begin
        mul_a = t;
        mul_b = t;
      end
      MS_A2T: begin
        mul_a = MW'(a2);
        mul_b = t;
      end
      MS_B2T: begin
        mul_a = MW'(b2);
        mul_b = t;
      end
      default: begin
        mul_a = MW'(a2);
        mul_b = MW'(b2);
      end
    endcase
  end

  assign full_prod = mul_a * mul_b;

  // The decision wraps in DEC_W bits, so every sum is taken modulo that width.
  always_comb begin
    unique case (cmd.dec_op)
      DO_INIT: dec_next = DEC_W'(b2) - prod + DEC_W'(a2 >> 2);
      DO_LOAD: dec_next = prod + DEC_W'(b2 >> 2);
      DO_ADD:  dec_next = dec + prod;
      DO_SUB:  dec_next = dec - prod;
      DO_SUB3: dec_next = dec - prod + (DEC_W'(a2) << 1) + DEC_W'(a2);
      default: dec_next = dec;
    endcase
  end

  always_ff @(posedge clk) begin
    t   <= t_next;
    dec <= dec_next;
    if (cmd.mul_en) begin
      prod <= full_prod[DEC_W-1:0];
    end
    if (cmd.save_load) begin
      saved <= prod;
    end
    if (cmd.a2_load) begin
      a2 <= prod[SQ_W-1:0];
    end
    if (cmd.b2_load) begin
      b2 <= prod[SQ_W-1:0];
    end
    if (cmd.start) begin
      cx <= center_x;
      cy <= center_y;
      x  <= '0;
      y  <= Y_W'(axis_b);
    end else begin
      if (cmd.x_inc) begin
        x <= x + X_W'(1);
      end
      if (cmd.y_dec) begin
        y <= y - Y_W'(1);
      end
    end
  end

  assign sts.dec_neg = dec[DEC_W-1];
  assign sts.dec_pos = !dec[DEC_W-1] && (dec != '0);
  assign sts.cmp_gt  = saved > prod;
  assign sts.y_zero  = (y == '0);

  // The offset is never negative while a pixel is shown.
  assign cxo = PW'(cx);
  assign cyo = PW'(cy);
  assign xo  = PW'(x);
  assign yo  = PW'(y);

  always_comb begin
    unique case (cmd.beat)
      2'd0: begin
        pixel_x = cxo + xo;
        pixel_y = cyo - yo;
      end
      2'd1: begin
        pixel_x = cxo - xo;
        pixel_y = cyo - yo;
      end
      2'd2: begin
        pixel_x = cxo + xo;
        pixel_y = cyo + yo;
      end
      default: begin
        pixel_x = cxo - xo;
        pixel_y = cyo + yo;
      end
    endcase
  end

endmodule

[rtl/mer_ctrl.sv]
// Controller: sequences the multiplier steps of each item and the four pixel beats of each step item.
module mer_ctrl import mer_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_mode,
  input  logic     pix_ready,
  input  mer_sts_t sts,
  output mer_cmd_t cmd,
  output logic     req_ready,
  output logic     pix_valid,
  output logic     pix_last
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_R1   = 2'd1;
  localparam logic [1:0] PH_R2   = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [1:0] LAST_BEAT = 2'd3;

  localparam logic [4:0] S_WAIT = 5'd0;
  localparam logic [4:0] S_ST0  = 5'd1;
  localparam logic [4:0] S_ST1  = 5'd2;
  localparam logic [4:0] S_ST2  = 5'd3;
  localparam logic [4:0] S_ST3  = 5'd4;
  localparam logic [4:0] S_ST4  = 5'd5;
  localparam logic [4:0] S_R1_0 = 5'd6;
  localparam logic [4:0] S_R1_1 = 5'd7;
  localparam logic [4:0] S_R1_2 = 5'd8;
  localparam logic [4:0] S_R1_3 = 5'd9;
  localparam logic [4:0] S_X1   = 5'd10;
  localparam logic [4:0] S_X2   = 5'd11;
  localparam logic [4:0] S_X3   = 5'd12;
  localparam logic [4:0] S_X4   = 5'd13;
  localparam logic [4:0] S_X5   = 5'd14;
  localparam logic [4:0] S_X6   = 5'd15;
  localparam logic [4:0] S_X7   = 5'd16;
  localparam logic [4:0] S_X8   = 5'd17;
  localparam logic [4:0] S_EMIT = 5'd18;
  localparam logic [4:0] S_U1_0 = 5'd19;
  localparam logic [4:0] S_U1_1 = 5'd20;
  localparam logic [4:0] S_U1_2 = 5'd21;
  localparam logic [4:0] S_U1_3 = 5'd22;
  localparam logic [4:0] S_U2_0 = 5'd23;
  localparam logic [4:0] S_U2_1 = 5'd24;
  localparam logic [4:0] S_U2_2 = 5'd25;
  localparam logic [4:0] S_U2_3 = 5'd26;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [1:0] beat;
  logic [1:0] beat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WAIT;
      phase <= PH_IDLE;
      beat  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      beat  <= beat_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    beat_next  = beat;
    cmd        = '0;
    cmd.beat   = beat;
    req_ready  = 1'b0;
    pix_valid  = 1'b0;
    pix_last   = 1'b0;
    unique case (state)
      S_WAIT: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_mode == MODE_START) begin
            cmd.start  = 1'b1;
            cmd.t_sel  = T_AXIS;
            phase_next = PH_R1;
            state_next = S_ST0;
          end else if (phase == PH_R1) begin
            state_next = S_R1_0;
          end else if (phase == PH_R2) begin
            state_next = S_EMIT;
          end
        end
      end
      // Start: a*a, b*b, then the region-1 decision.
      S_ST0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TT;
        state_next  = S_ST1;
      end
      S_ST1: begin
        cmd.a2_load = 1'b1;
        cmd.t_sel   = T_Y;
        state_next  = S_ST2;
      end
      S_ST2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TT;
        state_next  = S_ST3;
      end
      S_ST3: begin
        cmd.b2_load = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_A2T;
        state_next  = S_ST4;
      end
      S_ST4: begin
        cmd.dec_op = DO_INIT;
        state_next = S_WAIT;
      end
      // Region-1 test: a2*y against b2*x.
      S_R1_0: begin
        cmd.t_sel  = T_Y;
        state_next = S_R1_1;
      end
      S_R1_1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_A2T;
        cmd.t_sel   = T_X;
        state_next  = S_R1_2;
      end
      S_R1_2: begin
        cmd.save_load = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MS_B2T;
        state_next    = S_R1_3;
      end
      S_R1_3: begin
        if (sts.cmp_gt) begin
          state_next = S_EMIT;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_TT;
          state_next  = S_X1;
        end
      end
      // Region-2 entry decision, built term by term.
      S_X1: begin
        cmd.t_sel  = T_PX;
        state_next = S_X2;
      end
      S_X2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_B2T;
        state_next  = S_X3;
      end
      S_X3: begin
        cmd.dec_op = DO_LOAD;
        cmd.t_sel  = T_YM1;
        state_next = S_X4;
      end
      S_X4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TT;
        state_next  = S_X5;
      end
      S_X5: begin
        cmd.t_sel  = T_P;
        state_next = S_X6;
      end
      S_X6: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_A2T;
        state_next  = S_X7;
      end
      S_X7: begin
        cmd.dec_op  = DO_ADD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_A2B2;
        state_next  = S_X8;
      end
      S_X8: begin
        cmd.dec_op = DO_SUB;
        phase_next = PH_R2;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        pix_valid = 1'b1;
        pix_last  = (phase == PH_R2) && (beat == LAST_BEAT) && sts.y_zero;
        if (pix_ready) begin
          beat_next = beat + 2'd1;
          if (beat == LAST_BEAT) begin
            state_next = (phase == PH_R2) ? S_U2_0 : S_U1_0;
          end
        end
      end
      // Region-1 advance.
      S_U1_0: begin
        cmd.t_sel  = T_2X3;
        state_next = S_U1_1;
      end
      S_U1_1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_B2T;
        cmd.t_sel   = T_2Y2;
        state_next  = S_U1_2;
      end
      S_U1_2: begin
        cmd.dec_op = DO_ADD;
        if (sts.dec_neg) begin
          cmd.x_inc  = 1'b1;
          state_next = S_WAIT;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_A2T;
          state_next  = S_U1_3;
        end
      end
      S_U1_3: begin
        cmd.dec_op = DO_SUB;
        cmd.x_inc  = 1'b1;
        cmd.y_dec  = 1'b1;
        state_next = S_WAIT;
      end
      // Region-2 advance.
      S_U2_0: begin
        cmd.t_sel  = T_2Y;
        state_next = S_U2_1;
      end
      S_U2_1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_A2T;
        cmd.t_sel   = T_2X2;
        state_next  = S_U2_2;
      end
      S_U2_2: begin
        cmd.dec_op = DO_SUB3;
        if (sts.dec_pos) begin
          cmd.y_dec = 1'b1;
          if (sts.y_zero) begin
            phase_next = PH_DONE;
          end
          state_next = S_WAIT;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_B2T;
          state_next  = S_U2_3;
        end
      end
      S_U2_3: begin
        cmd.dec_op = DO_ADD;
        cmd.x_inc  = 1'b1;
        cmd.y_dec  = 1'b1;
        if (sts.y_zero) begin
          phase_next = PH_DONE;
        end
        state_next = S_WAIT;
      end
      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

endmodule

[rtl/midpoint_ellipse_rasterizer.sv]
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
//
//   Channel   Role    Beat contents
//   req       sink    mode, center_x, center_y, axis_a, axis_b
//   pix       source  pixel_x, pixel_y, last (four beats per step item)
//
// A start item gives no pixels.
// Each step item is worked through the one shared multiplier, used once per cycle
// with its product registered, around four pixel beats; the step that enters
// region 2 also builds the region-2 decision term by term.
// Reset is synchronous and returns the block to idle, where steps are ignored.
// A stalled pix beat holds its payload; no item is taken until all four beats
// of the current step have gone and the point has been advanced.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  mer_req_if.sink   req,
  mer_pix_if.source pix
);

  mer_cmd_t cmd;
  mer_sts_t sts;

  // The controller owns both handshakes; the datapath only sees command bits.
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .pix_ready (pix.ready),
    .sts       (sts),
    .cmd       (cmd),
    .req_ready (req.ready),
    .pix_valid (pix.valid),
    .pix_last  (pix.last)
  );

  // Pixel payload is formed from registers only, so it stays put under stall.
  mer_dp #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_dp (
    .clk      (clk),
    .center_x (req.center_x),
    .center_y (req.center_y),
    .axis_a   (req.axis_a),
    .axis_b   (req.axis_b),
    .cmd      (cmd),
    .sts      (sts),
    .pixel_x  (pix.pixel_x),
    .pixel_y  (pix.pixel_y)
  );

endmodule

[rtl/mer_checker.sv]
// Port-level checks of the ellipse rasterizer and their binding to the top level.
module mer_checker import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 req_mode,
  input logic                 pix_valid,
  input logic                 pix_ready,
  input logic [COORD_BITS+1:0] pix_x,
  input logic [COORD_BITS+1:0] pix_y,
  input logic                 pix_last
);

  // Reset leaves no pixel on offer.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("pixel offered right after reset");

  // Items are taken only while no pixel is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && pix_valid))
    else $error("item accepted while a pixel is pending");

  // A start item never produces a pixel on the next cycle.
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req_mode == MODE_START)) |=> !pix_valid)
    else $error("pixel after a start item");

  // After the final pixel the block is busy advancing, not offering more.
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready && pix_last) |=> (!pix_valid && !req_ready))
    else $error("activity right after the final pixel");

  // A stalled pixel beat keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_ready) |=>
      (pix_valid && $stable(pix_x) && $stable(pix_y) && $stable(pix_last)))
    else $error("pixel beat changed under stall");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
  .COORD_BITS (COORD_BITS)
) u_mer_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_mode  (req.mode),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_x     (pix.pixel_x),
  .pix_y     (pix.pixel_y),
  .pix_last  (pix.last)
);
